[src/lpuht_pkg.sv]
// Package for the linear-probe identifier hash table.
// Holds the item, result and command structs and the operation and status codes.
// Depends on nothing; every other file imports it.
package lpuht_pkg;

   localparam int LOG_SIZE_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [LOG_SIZE_BITS-1:0] LOG_SIZE_RESET = 5'd16;
   localparam logic                     CSR_IDX_LOG_SIZE = 1'b0;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_INSERT,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key_head;
      logic [63:0] key_tail;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
   } rsp_type;

   typedef struct packed {
      op_type                   op;
      logic [63:0]              key_head;
      logic [63:0]              key_tail;
      logic [31:0]              entry_value;
      logic [LOG_SIZE_BITS-1:0] slot_log2;
   } cmd_type;

endpackage

[src/lpuht_fifo.sv]
// Small first-in first-out queue of registers for any packed item type.
// Used between front and back and on the result side; imports lpuht_pkg for style only.
module lpuht_fifo
   import lpuht_pkg::*;
#(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wr_item,
   output logic     full,
   input  logic     pop,
   output item_type rd_item,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        store_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_item = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue holds more than its depth");

endmodule

[src/lpuht_front.sv]
// Front end: configuration register, item intake and classification into commands.
// Depends on lpuht_pkg; feeds the command queue ahead of lpuht_back.
module lpuht_front
   import lpuht_pkg::*;
#(
   parameter int LOG_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   input  logic                     push,
   input  req_type                  req_item,
   output logic                     full,
   input  logic                     cmd_full,
   input  logic                     init_busy,
   output logic                     cmd_push,
   output cmd_type                  cmd_item
);

   localparam logic [LOG_SIZE_BITS-1:0] MAX_LOG = LOG_SIZE_BITS'(LOG_DEPTH);

   logic [LOG_SIZE_BITS-1:0] slot_log2_ff;
   logic [LOG_SIZE_BITS-1:0] slot_log2_in;
   logic [LOG_SIZE_BITS-1:0] log_clamped;
   logic                     csr_write;
   op_type                   op;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_IDX_LOG_SIZE) ?
                      CSR_DATA_BITS'(slot_log2_ff) : '0;

   always_comb begin
      slot_log2_in = slot_log2_ff;
      if (csr_write && (paddr[2] == CSR_IDX_LOG_SIZE)) begin
         slot_log2_in = pwdata[LOG_SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_log2_ff <= LOG_SIZE_RESET;
      end else begin
         slot_log2_ff <= slot_log2_in;
      end
   end

   always_comb begin
      if (slot_log2_ff == '0) begin
         log_clamped = LOG_SIZE_BITS'(1);
      end else if (slot_log2_ff > MAX_LOG) begin
         log_clamped = MAX_LOG;
      end else begin
         log_clamped = slot_log2_ff;
      end
   end

   always_comb begin
      case (req_item.kind)
         KIND_LOOKUP: op = OP_LOOKUP;
         KIND_INSERT: op = OP_INSERT;
         KIND_CLEAR:  op = OP_CLEAR;
         default:     op = OP_NOP;
      endcase
   end

   assign full                 = cmd_full || init_busy;
   assign cmd_push             = push && !full;
   assign cmd_item.op          = op;
   assign cmd_item.key_head    = req_item.key_head;
   assign cmd_item.key_tail    = req_item.key_tail;
   assign cmd_item.entry_value = req_item.entry_value;
   assign cmd_item.slot_log2   = log_clamped;

endmodule

[src/lpuht_back.sv]
// Back end: slot memory, probe sequencer and clearing sweep.
// Depends on lpuht_pkg; pops the command queue and pushes the result queue.
module lpuht_back
   import lpuht_pkg::*;
#(
   parameter int LOG_DEPTH  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_item,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_item,
   output logic    init_busy
);

   localparam logic [VALUE_BITS-1:0] EMPTY_MARK = {VALUE_BITS{1'b1}};
   localparam logic [31:0]           EMPTY_OUT  = 32'(EMPTY_MARK);
   localparam int                    DEPTH      = 1 << LOG_DEPTH;

   typedef struct packed {
      logic [63:0]           key_head;
      logic [63:0]           key_tail;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE
   } state_type;

   slot_type mem [DEPTH];

   state_type            state_ff,    state_in;
   cmd_type              cmd_ff,      cmd_in;
   logic [LOG_DEPTH-1:0] slot_ff,     slot_in;
   logic [LOG_DEPTH-1:0] count_ff,    count_in;
   logic [LOG_DEPTH-1:0] sweep_ff,    sweep_in;
   logic                 clear_op_ff, clear_op_in;
   logic                 rsp_push_ff, rsp_push_in;
   rsp_type              rsp_ff,      rsp_in;
   slot_type             rd_ff;

   logic                 mem_we;
   logic [LOG_DEPTH-1:0] mem_waddr;
   slot_type             mem_wdata;
   logic [LOG_DEPTH-1:0] rd_addr;
   logic [LOG_DEPTH-1:0] mask_cur;
   logic [LOG_DEPTH-1:0] mask_head;
   logic [LOG_DEPTH-1:0] home;
   logic [LOG_DEPTH-1:0] slot_next;
   logic                 slot_empty;
   logic                 key_match;
   logic                 last_probe;

   assign mask_cur   = ~({LOG_DEPTH{1'b1}} << cmd_ff.slot_log2);
   assign mask_head  = ~({LOG_DEPTH{1'b1}} << cmd_item.slot_log2);
   assign home       = cmd_item.key_head[LOG_DEPTH-1:0] & mask_head;
   assign slot_next  = (slot_ff + 1'b1) & mask_cur;
   assign slot_empty = (rd_ff.value == EMPTY_MARK);
   assign key_match  = (rd_ff.key_head == cmd_ff.key_head) &&
                       (rd_ff.key_tail == cmd_ff.key_tail);
   assign last_probe = (count_ff == mask_cur);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      sweep_in    = sweep_ff;
      clear_op_in = clear_op_ff;
      rsp_push_in = 1'b0;
      rsp_in      = rsp_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = slot_ff;
      mem_wdata   = '{key_head: cmd_ff.key_head, key_tail: cmd_ff.key_tail,
                      value: VALUE_BITS'(cmd_ff.entry_value)};
      rd_addr     = slot_ff;
      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '{key_head: '0, key_tail: '0, value: EMPTY_MARK};
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == {LOG_DEPTH{1'b1}}) begin
               state_in = ST_IDLE;
               if (clear_op_ff) begin
                  rsp_push_in = 1'b1;
                  rsp_in      = '{status: STATUS_OK, found_value: EMPTY_OUT};
               end
            end
         end
         ST_IDLE: begin
            rd_addr = home;
            if (!cmd_empty && !rsp_full && !rsp_push_ff) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_item;
               slot_in  = home;
               count_in = '0;
               case (cmd_item.op)
                  OP_LOOKUP, OP_INSERT: begin
                     state_in = ST_PROBE;
                  end
                  OP_CLEAR: begin
                     state_in    = ST_SWEEP;
                     sweep_in    = '0;
                     clear_op_in = 1'b1;
                  end
                  default: begin
                     rsp_push_in = 1'b1;
                     rsp_in      = '{status: STATUS_OK, found_value: EMPTY_OUT};
                  end
               endcase
            end
         end
         ST_PROBE: begin
            rd_addr = slot_next;
            if (cmd_ff.op == OP_INSERT) begin
               if (slot_empty) begin
                  mem_we      = 1'b1;
                  state_in    = ST_IDLE;
                  rsp_push_in = 1'b1;
                  rsp_in      = '{status: STATUS_OK, found_value: EMPTY_OUT};
               end else if (last_probe) begin
                  state_in    = ST_IDLE;
                  rsp_push_in = 1'b1;
                  rsp_in      = '{status: STATUS_FULL, found_value: EMPTY_OUT};
               end else begin
                  slot_in  = slot_next;
                  count_in = count_ff + 1'b1;
               end
            end else begin
               if (slot_empty || (!key_match && last_probe)) begin
                  state_in    = ST_IDLE;
                  rsp_push_in = 1'b1;
                  rsp_in      = '{status: STATUS_NOT_FOUND, found_value: EMPTY_OUT};
               end else if (key_match) begin
                  state_in    = ST_IDLE;
                  rsp_push_in = 1'b1;
                  rsp_in      = '{status: STATUS_OK, found_value: 32'(rd_ff.value)};
               end else begin
                  slot_in  = slot_next;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         sweep_ff    <= '0;
         clear_op_ff <= 1'b0;
         rsp_push_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sweep_ff    <= sweep_in;
         clear_op_ff <= clear_op_in;
         rsp_push_ff <= rsp_push_in;
      end
      cmd_ff   <= cmd_in;
      slot_ff  <= slot_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_push  = rsp_push_ff;
   assign rsp_item  = rsp_ff;
   assign init_busy = (state_ff == ST_SWEEP) && !clear_op_ff;

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (count_ff <= mask_cur))
      else $error("probe ran past one pass");

   a_sweep_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !cmd_pop)
      else $error("command taken during sweep");

   a_single_push: assert property (@(posedge clock) disable iff (reset)
      rsp_push_ff |=> !rsp_push_ff)
      else $error("two results pushed back to back");

endmodule

[src/linear_probe_uuid_hash_table_unit.sv]
// Linear-probe hash table keyed by 128-bit identifiers: lookup, insert and clear.
// An item goes through the command queue, the slot read, the probe state and the result
// register into the result queue; each extra probe reads one more slot in the probe state.
// Clear sweeps every slot, one slot write per cycle on one memory port.
// Reset starts a sweep that empties every slot; full stays high until it ends.
// Depends on lpuht_pkg, lpuht_fifo, lpuht_front and lpuht_back.
module linear_probe_uuid_hash_table_unit
   import lpuht_pkg::*;
#(
   parameter int LOG_DEPTH  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   input  logic                     push,
   input  req_type                  req_item,
   output logic                     full,
   output logic                     empty,
   input  logic                     pop,
   output rsp_type                  rsp_item
);

   logic    cmd_push;
   cmd_type cmd_wr;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_rd;
   logic    init_busy;
   logic    rsp_push;
   rsp_type rsp_wr;
   logic    rsp_full;

   lpuht_front #(
      .LOG_DEPTH(LOG_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .cmd_full  (cmd_full),
      .init_busy (init_busy),
      .cmd_push  (cmd_push),
      .cmd_item  (cmd_wr)
   );

   lpuht_fifo #(
      .item_type(cmd_type)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_item (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_item (cmd_rd),
      .empty   (cmd_empty)
   );

   lpuht_back #(
      .LOG_DEPTH (LOG_DEPTH),
      .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_item  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_wr),
      .init_busy (init_busy)
   );

   lpuht_fifo #(
      .item_type(rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_item (rsp_wr),
      .full    (rsp_full),
      .pop     (pop),
      .rd_item (rsp_item),
      .empty   (empty)
   );

endmodule

[tb/tb.sv]
// Testbench for linear_probe_uuid_hash_table_unit: lookups, inserts, clears and table sizes.
// A tracking class predicts each result from its own copy of the slots; tasks drive the
// request and APB ports, a process drives the response pop. Depends on lpuht_pkg and the table RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpuht_pkg::*;

   localparam int SLOT_ADDR_BITS = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int POOL_DEPTH = 64;
   localparam logic [CSR_ADDR_BITS-1:0] LOG_SIZE_ADDR = CSR_ADDR_BITS'(4 * CSR_IDX_LOG_SIZE);

   class slot_table_tracker;
      logic [31:0] slot_val [int];
      logic [63:0] slot_head [int];
      logic [63:0] slot_tail [int];
      logic [LOG_SIZE_BITS-1:0] slot_log2 = LOG_SIZE_RESET;
      rsp_type pending_results [$];
      int n_errors, n_checked, n_lookups, n_hits, n_inserts, n_full, n_clears, n_ignored;

      function bit slot_empty(int unsigned s);
         return !slot_val.exists(s) || slot_val[s] == '1;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int unsigned lg, size, mask, s, n;
         lg = slot_log2;
         if (lg < 1) lg = 1;
         if (lg > SLOT_ADDR_BITS) lg = SLOT_ADDR_BITS;
         size = 1 << lg;
         mask = size - 1;
         s = r.key_head[31:0] & mask;
         e.status = STATUS_OK;
         e.found_value = '1;
         case (op_type'(r.kind))
            OP_LOOKUP: begin
               n_lookups++;
               e.status = STATUS_NOT_FOUND;
               for (n = 0; n < size; n++) begin
                  if (slot_empty(s)) break;
                  if (slot_head[s] == r.key_head && slot_tail[s] == r.key_tail) begin
                     e.status = STATUS_OK;
                     e.found_value = slot_val[s];
                     n_hits++;
                     break;
                  end
                  s = (s + 1) & mask;
               end
            end
            OP_INSERT: begin
               n_inserts++;
               e.status = STATUS_FULL;
               for (n = 0; n < size; n++) begin
                  if (slot_empty(s)) begin
                     slot_head[s] = r.key_head;
                     slot_tail[s] = r.key_tail;
                     slot_val[s] = r.entry_value;
                     e.status = STATUS_OK;
                     break;
                  end
                  s = (s + 1) & mask;
               end
               if (e.status == STATUS_FULL) n_full++;
            end
            OP_CLEAR: begin
               n_clears++;
               slot_val.delete();
            end
            default: n_ignored++;
         endcase
         pending_results = {pending_results, e};
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: status %0d, found_value %h",
                   got.status, got.found_value);
            n_errors++;
            return;
         end
         e = pending_results.pop_front();
         n_checked++;
         if (got.status !== e.status) begin
            $error("status mismatch: expected %0d, got %0d", e.status, got.status);
            n_errors++;
         end
         if (got.found_value !== e.found_value) begin
            $error("found_value mismatch: expected %h, got %h", e.found_value, got.found_value);
            n_errors++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;
   logic push = 1'b0;
   req_type req_item = '0;
   logic full;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_item;

   slot_table_tracker sb = new();
   bit hold_req = 1'b0;
   bit pressure_on = 1'b0;
   int hold_left = 0;
   int burst_left = 0;
   logic [63:0] pool_head [$];
   logic [63:0] pool_tail [$];

   int phase_log [9] = '{3, 2, 16, 5, 1, 8, 4, 10, 12};
   int phase_items [9] = '{60, 40, 150, 80, 30, 120, 60, 100, 60};
   bit phase_clear [9] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

   linear_probe_uuid_hash_table_unit DUT (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready),
      .push(push), .req_item(req_item), .full(full),
      .empty(empty), .pop(pop), .rsp_item(rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && push && !full) sb.note_request(req_item);
      if (!reset && pop && !empty) sb.check_response(rsp_item);
   end

   initial begin
      int mode, mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
               0: pop <= 1'b1;
               1: pop <= $urandom_range(0, 1);
               2: pop <= ($urandom_range(0, 3) != 0);
               default: pop <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      return $urandom_range(1, 10);
   endfunction

   function automatic req_type mk_req(op_type op, logic [63:0] h, logic [63:0] t,
                                      logic [31:0] v);
      req_type r;
      r.kind = op;
      r.key_head = h;
      r.key_tail = t;
      r.entry_value = v;
      return r;
   endfunction

   function automatic req_type make_random_req();
      req_type r;
      int unsigned pick, k, idx;
      r.key_head = {$urandom, $urandom};
      r.key_tail = {$urandom, $urandom};
      r.entry_value = $urandom;
      k = $urandom_range(0, 9);
      if (k < 5) r.key_head[15:0] = 16'($urandom_range(0, 15));
      else if (k == 5) r.key_head[15:0] = 16'hFFFF - 16'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.kind = OP_INSERT;
         k = $urandom_range(0, 19);
         if (k == 0) r.entry_value = '1;
         else if (k == 1) r.entry_value = '0;
         if (pool_head.size() > 0 && $urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, pool_head.size() - 1);
            r.key_head = pool_head[idx];
            r.key_tail = pool_tail[idx];
         end else begin
            pool_head = {pool_head, r.key_head};
            pool_tail = {pool_tail, r.key_tail};
            if (pool_head.size() > POOL_DEPTH) begin
               pool_head.delete(0);
               pool_tail.delete(0);
            end
         end
      end else if (pick < 97) begin
         r.kind = OP_LOOKUP;
         k = $urandom_range(0, 9);
         if (pool_head.size() > 0 && k < 8) begin
            idx = $urandom_range(0, pool_head.size() - 1);
            r.key_head = pool_head[idx];
            if (k < 7) r.key_tail = pool_tail[idx];
         end
      end else begin
         r.kind = OP_NOP;
      end
      return r;
   endfunction

   task automatic send_req(input req_type r, input bit last);
      int gap;
      gap = pressure_on ? 0 : pick_gap();
      if (last && gap == 0) gap = 1;
      req_item <= r;
      push <= 1'b1;
      do @(posedge clock); while (full);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_all(input req_type q [$]);
      int i;
      for (i = 0; i < q.size(); i++) send_req(q[i], i == q.size() - 1);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_slot_log2(input logic [LOG_SIZE_BITS-1:0] lg);
      logic [CSR_DATA_BITS-1:0] rd;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LOG_SIZE_ADDR;
      pwdata <= CSR_DATA_BITS'(lg);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (rd[LOG_SIZE_BITS-1:0] !== lg) begin
         $error("size register mismatch: expected %0d, got %0d", lg, rd[LOG_SIZE_BITS-1:0]);
         sb.n_errors++;
      end
      sb.slot_log2 = lg;
   endtask

   initial begin
      req_type plan [$];
      int p, i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (full);

      // two slots: fill, overflow, clear, reserved value
      set_slot_log2(LOG_SIZE_BITS'(0));
      plan = {plan, mk_req(OP_LOOKUP, '0, '0, '0)};
      plan = {plan, mk_req(OP_INSERT, '0, '0, '0)};
      plan = {plan, mk_req(OP_INSERT, '1, '1, 32'hFFFF_FFFE)};
      plan = {plan, mk_req(OP_LOOKUP, '0, '0, '1)};
      plan = {plan, mk_req(OP_LOOKUP, '1, '1, '0)};
      plan = {plan, mk_req(OP_INSERT, 64'd2, 64'd5, 32'd7)};
      plan = {plan, mk_req(OP_LOOKUP, 64'd2, 64'd5, '0)};
      plan = {plan, mk_req(OP_LOOKUP, '0, 64'd1, '0)};
      plan = {plan, mk_req(OP_NOP, {$urandom, $urandom}, {$urandom, $urandom}, $urandom)};
      plan = {plan, mk_req(OP_CLEAR, '1, '0, '1)};
      plan = {plan, mk_req(OP_LOOKUP, '0, '0, '0)};
      plan = {plan, mk_req(OP_INSERT, 64'd4, 64'd9, '1)};
      plan = {plan, mk_req(OP_LOOKUP, 64'd4, 64'd9, '0)};
      plan = {plan, mk_req(OP_INSERT, 64'd6, 64'd1, 32'h0000_1234)};
      send_all(plan);
      plan.delete();
      drain();

      // grow without clearing, then shrink back
      set_slot_log2(LOG_SIZE_BITS'(31));
      plan = {plan, mk_req(OP_LOOKUP, 64'd6, 64'd1, '0)};
      plan = {plan, mk_req(OP_INSERT, 64'h0000_0000_0001_0006, 64'd3, 32'h0000_55AA)};
      send_all(plan);
      plan.delete();
      drain();
      set_slot_log2(LOG_SIZE_BITS'(1));
      plan = {plan, mk_req(OP_LOOKUP, 64'd6, 64'd1, '0)};
      send_all(plan);
      plan.delete();

      for (p = 0; p < 9; p++) begin
         drain();
         set_slot_log2(LOG_SIZE_BITS'(phase_log[p]));
         if (phase_clear[p])
            plan = {plan, mk_req(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                                 $urandom)};
         for (i = 0; i < phase_items[p]; i++) plan = {plan, make_random_req()};
         if (p == 2) begin
            pressure_on = 1'b1;
            hold_req = 1'b1;
         end
         send_all(plan);
         plan.delete();
         pressure_on = 1'b0;
      end

      drain();
      $display("Covered %0d lookups (%0d hits), %0d inserts (%0d rejected as full), %0d clears,",
               sb.n_lookups, sb.n_hits, sb.n_inserts, sb.n_full, sb.n_clears);
      $display("%0d ignored ops, table sizes 2 to 65536 slots; %0d results checked, %0d errors",
               sb.n_ignored, sb.n_checked, sb.n_errors);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
